// ===== rtl/core/tag_sighting_table_top_assert.svh =====
// assertion macros used by the table top module
`ifndef TAG_SIGHTING_TABLE_TOP_ASSERT_SVH
`define TAG_SIGHTING_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tst_pkg.sv =====
package tst_pkg;

	localparam int TABLE_DEPTH = 8;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [31:0] CUTOFF_RESET = 32'd8096;

	typedef enum logic [1:0] {
		ST_REFRESHED = 2'd0,
		ST_KEPT      = 2'd1,
		ST_INSERTED  = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] tag_id;
		logic [7:0]  signal_level;
		logic [31:0] now_tick;
	} sighting_t;

	typedef struct packed {
		status_t     status;
		logic [2:0]  slot;
		logic [15:0] entry_id;
		logic [7:0]  entry_level;
		logic [31:0] entry_tick;
	} result_t;

	// query that walks down the row of cells, one hop per cycle
	typedef struct packed {
		logic             valid;
		logic [15:0]      tag_id;
		logic [7:0]       level;
		logic [31:0]      now_tick;
		logic [31:0]      limit;
		logic             match_found;
		logic [IDX_W-1:0] match_idx;
		logic             match_keep;
		logic [7:0]       match_level;
		logic [31:0]      match_tick;
		logic             stale_found;
		logic [IDX_W-1:0] stale_idx;
	} probe_t;

	// entry update broadcast to the cells
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic [15:0]      tag_id;
		logic [7:0]       level;
		logic [31:0]      tick;
	} wr_t;

	function automatic logic [2:0] slot_of(input logic [IDX_W-1:0] idx);
		slot_of = 3'(idx);
	endfunction

endpackage

// ===== rtl/core/tag_sighting_table_top.sv =====
// tag sighting table: keeps the most recent radio tag sightings in a row of cells.
// a sighting is a command transfer: it is taken at a clock edge with start high
// and busy low; busy then stays high until the table update has landed.
// the query walks the row one cell per cycle, through the probe register and
// each cell's output register; done then strobes the result, and a new
// sighting is taken only after busy has dropped, so transfers never overlap;
// the walk through the cells sets the spacing between sightings.
// each result stays on the result port until the next one and is marked by done
// for a single cycle; the receiver cannot stall, so nothing is held back.
// the cutoff register is written over its own channel (cfg_valid/cfg_ready);
// cfg_ready is always high; the user writes only while the block is idle (unenforced).
// reset clears every entry to zero, sets the cutoff to 8096 ticks and drops busy.
module tag_sighting_table_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tst_pkg::sighting_t sighting,
	output logic               done,
	output tst_pkg::result_t   result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);
	import tst_pkg::*;

	logic [31:0] cutoff_q;
	logic        busy_q;
	logic        done_q;
	result_t     result_q;
	wr_t         wr_q;
	probe_t      probe_q;
	probe_t      probe_nxt;
	probe_t      chain [TABLE_DEPTH+1];
	probe_t      tail;
	result_t     res_nxt;
	wr_t         wr_nxt;
	logic        accept;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;
	assign chain[0]  = probe_q;
	assign tail      = chain[TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		tst_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.idx   (IDX_W'(i)),
			.pin   (chain[i]),
			.wr    (wr_q),
			.pout  (chain[i+1])
		);
	end

	// query entering the row
	always_comb begin
		probe_nxt = '0;
		if (accept) begin
			probe_nxt.valid    = 1'b1;
			probe_nxt.tag_id   = sighting.tag_id;
			probe_nxt.level    = sighting.signal_level;
			probe_nxt.now_tick = sighting.now_tick;
			probe_nxt.limit    = sighting.now_tick - cutoff_q;
		end
	end

	// decide at the end of the row
	always_comb begin
		res_nxt = '0;
		wr_nxt  = '0;
		if (tail.match_found) begin
			res_nxt.slot     = slot_of(tail.match_idx);
			res_nxt.entry_id = tail.tag_id;
			if (tail.match_keep) begin
				res_nxt.status      = ST_KEPT;
				res_nxt.entry_level = tail.match_level;
				res_nxt.entry_tick  = tail.match_tick;
			end else begin
				res_nxt.status      = ST_REFRESHED;
				res_nxt.entry_level = tail.level;
				res_nxt.entry_tick  = tail.now_tick;
				wr_nxt.valid        = tail.valid;
				wr_nxt.idx          = tail.match_idx;
			end
		end else if (tail.stale_found) begin
			res_nxt.status      = ST_INSERTED;
			res_nxt.slot        = slot_of(tail.stale_idx);
			res_nxt.entry_id    = tail.tag_id;
			res_nxt.entry_level = tail.level;
			res_nxt.entry_tick  = tail.now_tick;
			wr_nxt.valid        = tail.valid;
			wr_nxt.idx          = tail.stale_idx;
		end else begin
			res_nxt.status = ST_FULL;
		end
		wr_nxt.tag_id = tail.tag_id;
		wr_nxt.level  = tail.level;
		wr_nxt.tick   = tail.now_tick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			probe_q  <= '0;
			wr_q     <= '0;
			result_q <= '0;
		end else begin
			if (cfg_valid) begin
				cutoff_q <= cfg_data;
			end
			probe_q <= probe_nxt;
			if (accept) begin
				busy_q <= 1'b1;
			end
			done_q <= tail.valid;
			wr_q   <= wr_nxt;
			if (tail.valid) begin
				result_q <= res_nxt;
			end
			// update lands in the cells at the same edge
			if (done_q) begin
				busy_q <= 1'b0;
			end
		end
	end

`include "tag_sighting_table_top_assert.svh"

	`TST_ASSERT_NOW(a_done_busy, done_q, busy_q, "result strobe outside a transfer")
	`TST_ASSERT_NEXT(a_accept_busy, accept, busy_q, "busy not raised after transfer")
	`TST_ASSERT_NEXT(a_done_release, done_q, !busy_q && !done_q, "busy held after result")
	`TST_ASSERT_NOW(a_tail_busy, tail.valid, busy_q && !done_q, "query in row while idle")
	`TST_ASSERT_NOW(a_full_zero, done_q && (result_q.status == ST_FULL), (result_q.slot == 3'd0) && (result_q.entry_tick == 32'd0), "full result not zeroed")

endmodule

// ===== rtl/core/tst_cell.sv =====
module tst_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [tst_pkg::IDX_W-1:0] idx,
	input  tst_pkg::probe_t          pin,
	input  tst_pkg::wr_t             wr,
	output tst_pkg::probe_t          pout
);
	import tst_pkg::*;

	logic [15:0] id_q;
	logic [7:0]  level_q;
	logic [31:0] tick_q;
	logic        hit;
	logic        stale;
	probe_t      nxt;

	assign hit   = (id_q == pin.tag_id);
	assign stale = (tick_q < pin.limit);

	always_comb begin
		nxt = pin;
		// first matching entry wins
		if (!pin.match_found && hit) begin
			nxt.match_found = 1'b1;
			nxt.match_idx   = idx;
			nxt.match_keep  = !((level_q >= pin.level) || stale);
			nxt.match_level = level_q;
			nxt.match_tick  = tick_q;
		end
		if (!pin.stale_found && stale) begin
			nxt.stale_found = 1'b1;
			nxt.stale_idx   = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q    <= '0;
			level_q <= '0;
			tick_q  <= '0;
			pout    <= '0;
		end else begin
			pout <= nxt;
			if (wr.valid && (wr.idx == idx)) begin
				id_q    <= wr.tag_id;
				level_q <= wr.level;
				tick_q  <= wr.tick;
			end
		end
	end

endmodule
